### sv/pld_pkg.sv
// shared constants for the point to line distance block
// no dependencies; imported by every module of the block
`default_nettype none

package pld_pkg;

  // default coordinate width in bits
  localparam int COORD_WIDTH_DEF = 16;

  // fraction bits of the projection parameter
  localparam int T_FRAC = 16;

  // residual components are cut down by this many bits before squaring
  localparam int RES_SHIFT = 8;

  // mode bit positions
  localparam int MODE_CLAMP_START_BIT = 0;
  localparam int MODE_CLAMP_END_BIT   = 1;

  // cycles from an accepted request to its result strobe
  function automatic int pld_latency(input int cw);
    pld_latency = 2 * cw + 37;
  endfunction

endpackage

`default_nettype wire

### sv/pld_divider.sv
// pipelined unsigned restoring divider, one quotient bit per stage
// imports pld_pkg; used by point_line_distance for the projection parameter
`default_nettype none

module pld_divider
  import pld_pkg::*;
#(
  parameter int NW   = 53,
  parameter int DENW = 34,
  parameter int QW   = 33,
  parameter int SW   = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_vld,
  input  wire logic [NW-1:0]   in_num,
  input  wire logic [DENW-1:0] in_den,
  input  wire logic [SW-1:0]   in_side,
  output logic                 out_vld,
  output logic [QW-1:0]        out_quo,
  output logic [SW-1:0]        out_side
);

  localparam int EW = ((NW > DENW + QW) ? NW : DENW + QW) + 1;

  logic              vld_r  [0:QW];
  logic [NW-1:0]     rem_r  [0:QW];
  logic [QW-1:0]     quo_r  [0:QW];
  logic [DENW-1:0]   den_r  [0:QW];
  logic [SW-1:0]     side_r [0:QW];

  logic [NW-1:0]     rem_nxt [0:QW-1];
  logic [QW-1:0]     quo_nxt [0:QW-1];

  // trial subtract of the shifted divisor, one bit per stage
  always_comb begin
    logic [EW-1:0] rem_ext;
    logic [EW-1:0] shf;
    for (int k = 0; k < QW; k++) begin
      rem_ext = EW'(rem_r[k]);
      shf     = EW'(den_r[k]) << (QW - 1 - k);
      if (rem_ext >= shf) begin
        rem_nxt[k] = NW'(rem_ext - shf);
        quo_nxt[k] = quo_r[k] | (QW'(1) << (QW - 1 - k));
      end else begin
        rem_nxt[k] = rem_r[k];
        quo_nxt[k] = quo_r[k];
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 0; k < QW; k++) vld_r[k+1] <= vld_r[k];
    end
    rem_r[0]  <= in_num;
    quo_r[0]  <= '0;
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
    for (int k = 0; k < QW; k++) begin
      rem_r[k+1]  <= rem_nxt[k];
      quo_r[k+1]  <= quo_nxt[k];
      den_r[k+1]  <= den_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  assign out_vld  = vld_r[QW];
  assign out_quo  = quo_r[QW];
  assign out_side = side_r[QW];

endmodule

`default_nettype wire

### sv/pld_sqrt.sv
// pipelined truncating integer square root, one root bit per stage
// imports pld_pkg; used by point_line_distance for the final length
`default_nettype none

module pld_sqrt
  import pld_pkg::*;
#(
  parameter int RADW = 52
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic [RADW-1:0]   in_rad,
  output logic                   out_vld,
  output logic [RADW/2-1:0]      out_root
);

  localparam int ROW = RADW / 2;

  logic            vld_r [0:ROW];
  logic [RADW-1:0] n_r   [0:ROW];
  logic [RADW-1:0] res_r [0:ROW];

  logic [RADW-1:0] n_nxt   [0:ROW-1];
  logic [RADW-1:0] res_nxt [0:ROW-1];

  // digit recurrence, the test bit drops by two places per stage
  always_comb begin
    logic [RADW-1:0] bitv;
    logic [RADW-1:0] trial;
    for (int k = 0; k < ROW; k++) begin
      bitv  = RADW'(1) << (2 * (ROW - 1 - k));
      trial = res_r[k] + bitv;
      if (n_r[k] >= trial) begin
        n_nxt[k]   = n_r[k] - trial;
        res_nxt[k] = (res_r[k] >> 1) + bitv;
      end else begin
        n_nxt[k]   = n_r[k];
        res_nxt[k] = res_r[k] >> 1;
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ROW; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 0; k < ROW; k++) vld_r[k+1] <= vld_r[k];
    end
    n_r[0]   <= in_rad;
    res_r[0] <= '0;
    for (int k = 0; k < ROW; k++) begin
      n_r[k+1]   <= n_nxt[k];
      res_r[k+1] <= res_nxt[k];
    end
  end

  assign out_vld  = vld_r[ROW];
  assign out_root = res_r[ROW][ROW-1:0];

endmodule

`default_nettype wire

### sv/point_line_distance.sv
// distance from a point to a line, ray or segment in signed fixed point
// imports pld_pkg; instantiates pld_divider and pld_sqrt
//
// Usage: a request (point, start, end, mode) is taken on every rising
// edge with start high and busy low. busy is always low: the block is a
// fully pipelined datapath and takes one request every cycle.
// The result appears on out_distance with out_valid high for exactly
// one cycle, in request order. The pipeline holds the divider
// (COORD_WIDTH+18 stages, an input stage and one quotient bit each) and
// the square root (COORD_WIDTH+11 stages, an input stage and one root
// bit each) plus eight stages of difference, product, residual, select
// and output logic.
// The receiver cannot hold results off, and no stall exists anywhere.
// Reset clears all valid bits; requests in flight are dropped and no
// strobe appears until a new request has passed through.
// mode bit 0 clamps before the start point, bit 1 beyond the end point;
// coincident line points give the distance to the start point.
`default_nettype none

module point_line_distance
  import pld_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_y,
  input  wire logic [1:0]                    in_mode,
  output logic                               out_valid,
  output logic [COORD_WIDTH:0]               out_distance
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;                 // coordinate differences
  localparam int SQW  = 2 * DW;                 // sums of squares
  localparam int DOTW = 2 * DW + 1;             // signed dot product
  localparam int NW   = DOTW + T_FRAC;          // dividend
  localparam int QMW  = CW + T_FRAC + 1;        // quotient magnitude
  localparam int TQW  = QMW + 1;                // signed quotient
  localparam int PW   = TQW + DW;               // quotient times difference
  localparam int RSW  = CW + T_FRAC + 2;        // signed residual
  localparam int AW   = RSW - RES_SHIFT;        // shifted residual magnitude
  localparam int RADW = 2 * AW;                 // square root input
  localparam int ROW  = RADW / 2;
  localparam int SIDEW = 4 + 2 * SQW + 4 * DW;
  localparam int OSH  = T_FRAC - RES_SHIFT;

  assign busy = 1'b0;

  // stage 1: differences
  logic                 s1_vld_r;
  logic signed [DW-1:0] s1_dx_r, s1_dy_r, s1_ux_r, s1_uy_r, s1_wx_r, s1_wy_r;
  logic [1:0]           s1_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
    s1_dx_r   <= DW'(in_end_x) - DW'(in_start_x);
    s1_dy_r   <= DW'(in_end_y) - DW'(in_start_y);
    s1_ux_r   <= DW'(in_point_x) - DW'(in_start_x);
    s1_uy_r   <= DW'(in_point_y) - DW'(in_start_y);
    s1_wx_r   <= DW'(in_point_x) - DW'(in_end_x);
    s1_wy_r   <= DW'(in_point_y) - DW'(in_end_y);
    s1_mode_r <= in_mode;
  end

  // stage 2: products
  logic                   s2_vld_r;
  logic signed [2*DW-1:0] s2_dxdx_r, s2_dydy_r, s2_uxdx_r, s2_uydy_r;
  logic signed [2*DW-1:0] s2_uxux_r, s2_uyuy_r, s2_wxwx_r, s2_wywy_r;
  logic signed [DW-1:0]   s2_dx_r, s2_dy_r, s2_ux_r, s2_uy_r;
  logic [1:0]             s2_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    s2_dxdx_r <= s1_dx_r * s1_dx_r;
    s2_dydy_r <= s1_dy_r * s1_dy_r;
    s2_uxdx_r <= s1_ux_r * s1_dx_r;
    s2_uydy_r <= s1_uy_r * s1_dy_r;
    s2_uxux_r <= s1_ux_r * s1_ux_r;
    s2_uyuy_r <= s1_uy_r * s1_uy_r;
    s2_wxwx_r <= s1_wx_r * s1_wx_r;
    s2_wywy_r <= s1_wy_r * s1_wy_r;
    s2_dx_r   <= s1_dx_r;
    s2_dy_r   <= s1_dy_r;
    s2_ux_r   <= s1_ux_r;
    s2_uy_r   <= s1_uy_r;
    s2_mode_r <= s1_mode_r;
  end

  // stage 3: squared length, dot product, squared distances to both ends
  logic                   s3_vld_r;
  logic [SQW-1:0]         s3_len2_r, s3_su2_r, s3_sw2_r;
  logic signed [DOTW-1:0] s3_dot_r;
  logic signed [DW-1:0]   s3_dx_r, s3_dy_r, s3_ux_r, s3_uy_r;
  logic [1:0]             s3_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
    s3_len2_r <= SQW'(s2_dxdx_r) + SQW'(s2_dydy_r);
    s3_su2_r  <= SQW'(s2_uxux_r) + SQW'(s2_uyuy_r);
    s3_sw2_r  <= SQW'(s2_wxwx_r) + SQW'(s2_wywy_r);
    s3_dot_r  <= DOTW'(s2_uxdx_r) + DOTW'(s2_uydy_r);
    s3_dx_r   <= s2_dx_r;
    s3_dy_r   <= s2_dy_r;
    s3_ux_r   <= s2_ux_r;
    s3_uy_r   <= s2_uy_r;
    s3_mode_r <= s2_mode_r;
  end

  // divider feed: magnitude of the scaled dot product, sign on the side
  logic             dot_neg;
  logic [DOTW-1:0]  dot_mag;
  logic [NW-1:0]    div_num;
  logic [SIDEW-1:0] div_side_in, div_side_out;
  logic             div_vld;
  logic [QMW-1:0]   div_quo;

  always_comb begin
    dot_neg     = s3_dot_r[DOTW-1];
    dot_mag     = dot_neg ? DOTW'(-s3_dot_r) : DOTW'(s3_dot_r);
    div_num     = NW'(dot_mag) << T_FRAC;
    div_side_in = {s3_mode_r, dot_neg, (s3_len2_r == '0), s3_su2_r, s3_sw2_r,
                   s3_ux_r, s3_uy_r, s3_dx_r, s3_dy_r};
  end

  pld_divider #(
    .NW   (NW),
    .DENW (SQW),
    .QW   (QMW),
    .SW   (SIDEW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s3_vld_r),
    .in_num   (div_num),
    .in_den   (s3_len2_r),
    .in_side  (div_side_in),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side_out)
  );

  logic [1:0]           dv_mode;
  logic                 dv_neg, dv_zero;
  logic [SQW-1:0]       dv_su2, dv_sw2;
  logic signed [DW-1:0] dv_ux, dv_uy, dv_dx, dv_dy;

  assign {dv_mode, dv_neg, dv_zero, dv_su2, dv_sw2, dv_ux, dv_uy, dv_dx, dv_dy} =
    div_side_out;

  // stage a: signed projection, clamp decisions, projected offsets
  logic signed [TQW-1:0] tq_nxt;
  logic                  near_nxt, far_nxt;

  always_comb begin
    tq_nxt   = dv_neg ? -TQW'(div_quo) : TQW'(div_quo);
    near_nxt = dv_zero ||
               (dv_mode[MODE_CLAMP_START_BIT] && dv_neg && (div_quo != '0));
    far_nxt  = !near_nxt && dv_mode[MODE_CLAMP_END_BIT] && !dv_neg &&
               (div_quo > (QMW'(1) << T_FRAC));
  end

  logic                 sa_vld_r, sa_near_r, sa_far_r;
  logic signed [PW-1:0] sa_px_r, sa_py_r;
  logic signed [DW-1:0] sa_ux_r, sa_uy_r;
  logic [SQW-1:0]       sa_su2_r, sa_sw2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sa_vld_r <= 1'b0;
    else        sa_vld_r <= div_vld;
    sa_px_r   <= tq_nxt * dv_dx;
    sa_py_r   <= tq_nxt * dv_dy;
    sa_near_r <= near_nxt;
    sa_far_r  <= far_nxt;
    sa_ux_r   <= dv_ux;
    sa_uy_r   <= dv_uy;
    sa_su2_r  <= dv_su2;
    sa_sw2_r  <= dv_sw2;
  end

  // stage b: residual of the point against its projection
  logic                  sb_vld_r, sb_near_r, sb_far_r;
  logic signed [RSW-1:0] sb_rx_r, sb_ry_r;
  logic [SQW-1:0]        sb_su2_r, sb_sw2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sb_vld_r <= 1'b0;
    else        sb_vld_r <= sa_vld_r;
    sb_rx_r   <= RSW'((PW'(sa_ux_r) <<< T_FRAC) - sa_px_r);
    sb_ry_r   <= RSW'((PW'(sa_uy_r) <<< T_FRAC) - sa_py_r);
    sb_near_r <= sa_near_r;
    sb_far_r  <= sa_far_r;
    sb_su2_r  <= sa_su2_r;
    sb_sw2_r  <= sa_sw2_r;
  end

  // stage c: magnitudes, truncated
  logic [RSW-1:0] rx_mag, ry_mag;

  always_comb begin
    rx_mag = sb_rx_r[RSW-1] ? RSW'(-sb_rx_r) : RSW'(sb_rx_r);
    ry_mag = sb_ry_r[RSW-1] ? RSW'(-sb_ry_r) : RSW'(sb_ry_r);
  end

  logic           sc_vld_r, sc_near_r, sc_far_r;
  logic [AW-1:0]  sc_ax_r, sc_ay_r;
  logic [SQW-1:0] sc_su2_r, sc_sw2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sc_vld_r <= 1'b0;
    else        sc_vld_r <= sb_vld_r;
    sc_ax_r   <= rx_mag[RSW-1:RES_SHIFT];
    sc_ay_r   <= ry_mag[RSW-1:RES_SHIFT];
    sc_near_r <= sb_near_r;
    sc_far_r  <= sb_far_r;
    sc_su2_r  <= sb_su2_r;
    sc_sw2_r  <= sb_sw2_r;
  end

  // stage d: squared residual components
  logic            sd_vld_r, sd_near_r, sd_far_r;
  logic [RADW-1:0] sd_ax2_r, sd_ay2_r;
  logic [SQW-1:0]  sd_su2_r, sd_sw2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sd_vld_r <= 1'b0;
    else        sd_vld_r <= sc_vld_r;
    sd_ax2_r  <= sc_ax_r * sc_ax_r;
    sd_ay2_r  <= sc_ay_r * sc_ay_r;
    sd_near_r <= sc_near_r;
    sd_far_r  <= sc_far_r;
    sd_su2_r  <= sc_su2_r;
    sd_sw2_r  <= sc_sw2_r;
  end

  // radicand select; end-point distances are scaled to match the root shift
  logic [RADW-1:0] rad_nxt;

  always_comb begin
    if (sd_near_r)     rad_nxt = RADW'(sd_su2_r) << T_FRAC;
    else if (sd_far_r) rad_nxt = RADW'(sd_sw2_r) << T_FRAC;
    else               rad_nxt = sd_ax2_r + sd_ay2_r;
  end

  logic           sq_vld;
  logic [ROW-1:0] sq_root;

  pld_sqrt #(
    .RADW (RADW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sd_vld_r),
    .in_rad   (rad_nxt),
    .out_vld  (sq_vld),
    .out_root (sq_root)
  );

  // output register with saturation
  logic          out_valid_r;
  logic [CW:0]   out_distance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= sq_vld;
    out_distance_r <= sq_root[ROW-1] ? '1 : sq_root[ROW-2:OSH];
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

endmodule

`default_nettype wire

### sv/pld_checker.sv
// port level checks for point_line_distance, bound to the top level
// imports pld_pkg for the pipeline latency
`default_nettype none

module pld_checker
  import pld_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input wire logic signed [COORD_WIDTH-1:0] in_start_x,
  input wire logic signed [COORD_WIDTH-1:0] in_start_y,
  input wire logic                          out_valid,
  input wire logic [COORD_WIDTH:0]          out_distance
);

  localparam int LAT = pld_latency(COORD_WIDTH);
  localparam int CNTW = $clog2(LAT + 1);

  // cycles since reset, saturating at the latency
  logic [CNTW-1:0] since_rst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) since_rst_r <= '0;
    else if (since_rst_r != CNTW'(LAT)) since_rst_r <= since_rst_r + 1'b1;
  end

  logic on_start;
  assign on_start = (in_point_x == in_start_x) && (in_point_y == in_start_y);

  // the block never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // no strobe before a request can have passed the pipeline
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (since_rst_r != CNTW'(LAT)) |-> !out_valid)
    else $error("result strobe too early after reset");

  // one strobe per request, at the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (since_rst_r == CNTW'(LAT)) |-> (out_valid == $past(start && !busy, LAT)))
    else $error("result strobe does not match request timing");

  // a point on the start point has zero distance in every mode
  a_zero_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    ((since_rst_r == CNTW'(LAT)) && out_valid && $past(on_start, LAT))
      |-> (out_distance == '0))
    else $error("nonzero distance for point on start point");

endmodule

bind point_line_distance pld_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pld_checker (.*);

`default_nettype wire

### verif/point_line_distance_checker.sv
// checker for the point to line distance block: predicts each distance and compares
// depends on the ports of point_line_distance only
`default_nettype none

module point_line_distance_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [15:0] in_point_x,
  input  wire logic signed [15:0] in_point_y,
  input  wire logic signed [15:0] in_start_x,
  input  wire logic signed [15:0] in_start_y,
  input  wire logic signed [15:0] in_end_x,
  input  wire logic signed [15:0] in_end_y,
  input  wire logic [1:0]         in_mode,
  input  wire logic               out_valid,
  input  wire logic [16:0]        out_distance,
  output int                      fail_count,
  output int                      pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int T_SCALE = 16;
  localparam int CUT = 8;
  localparam logic [1:0] CLAMP_START = 2'b01;
  localparam logic [1:0] CLAMP_END = 2'b10;

  logic [16:0] distance_q[$];

  // truncated integer square root
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs64(input longint a);
    return a < 0 ? longint'(-a) : longint'(a);
  endfunction

  function automatic logic [16:0] clip17(input longint unsigned d);
    return d > 64'h1ffff ? 17'h1ffff : d[16:0];
  endfunction

  function automatic logic [16:0] length_of(input longint ax, input longint ay);
    return clip17(root_floor(abs64(ax) * abs64(ax) + abs64(ay) * abs64(ay)));
  endfunction

  // distance from point to line, ray or segment
  function automatic logic [16:0] predict_distance(
      input longint px, py, vx, vy, wx, wy, input logic [1:0] mode);
    longint dx, dy, ux, uy, len2, dot, tq, rx, ry;
    longint unsigned ax, ay;
    dx = wx - vx; dy = wy - vy;
    ux = px - vx; uy = py - vy;
    len2 = dx * dx + dy * dy;
    if (len2 == 0) return length_of(ux, uy);
    dot = ux * dx + uy * dy;
    tq = (dot * (64'sd1 <<< T_SCALE)) / len2;
    if ((mode & CLAMP_START) != 0 && tq < 0) return length_of(ux, uy);
    if ((mode & CLAMP_END) != 0 && tq > (64'sd1 <<< T_SCALE))
      return length_of(px - wx, py - wy);
    rx = ux * (64'sd1 <<< T_SCALE) - tq * dx;
    ry = uy * (64'sd1 <<< T_SCALE) - tq * dy;
    ax = abs64(rx) >> CUT;
    ay = abs64(ry) >> CUT;
    return clip17(root_floor(ax * ax + ay * ay) >> (T_SCALE - CUT));
  endfunction

  assign pending_count = distance_q.size();

  // predict on request, compare on strobe
  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (start && !busy)
        distance_q.push_back(predict_distance(in_point_x, in_point_y, in_start_x,
                                              in_start_y, in_end_x, in_end_y,
                                              in_mode));
      if (out_valid) begin
        if (distance_q.size() == 0) begin
          $error("unexpected distance %0d", out_distance);
          fail_count <= fail_count + 1;
        end else if (distance_q[0] !== out_distance) begin
          $error("distance: expected %0d actual %0d", distance_q[0], out_distance);
          void'(distance_q.pop_front());
          fail_count <= fail_count + 1;
        end else begin
          void'(distance_q.pop_front());
        end
      end
    end
  end
endmodule

`default_nettype wire

### verif/point_line_distance_tb.sv
// testbench top for point_line_distance: drives requests and gives the verdict
// depends on pld_pkg, point_line_distance and point_line_distance_checker
`default_nettype none

module point_line_distance_tb
  import pld_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT = pld_latency(16);
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] px = '0, py = '0, vx = '0, vy = '0, wx = '0, wy = '0;
  logic [1:0] mode = '0;
  logic out_valid;
  logic [16:0] out_distance;
  int fail_count, pending_count;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  point_line_distance i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(px), .in_point_y(py), .in_start_x(vx), .in_start_y(vy),
    .in_end_x(wx), .in_end_y(wy), .in_mode(mode),
    .out_valid(out_valid), .out_distance(out_distance)
  );

  point_line_distance_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(px), .in_point_y(py), .in_start_x(vx), .in_start_y(vy),
    .in_end_x(wx), .in_end_y(wy), .in_mode(mode),
    .out_valid(out_valid), .out_distance(out_distance),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL point_line_distance");
      $finish;
    end
  end

  // random coordinate: small half the time, else full range or extreme
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1, 2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // present one request and hold it until taken, then optionally gap
  task automatic send_request(input logic [15:0] a, b, c, d, e, f, input logic [1:0] m,
                              input bit allow_gap);
    int gap;
    px <= a; py <= b; vx <= c; vy <= d; wx <= e; wy <= f; mode <= m;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = 0;
    if (allow_gap && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int wait_cnt;
    logic [15:0] sx, sy, ex, ey;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, coincident points, each clamp direction
    send_request(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 2'd0, 0);
    send_request(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 2'd0, 0);
    send_request(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 2'd3, 0);
    send_request(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 2'd1, 0);
    send_request(16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 2'd2, 0);
    for (int m = 0; m < 4; m++) begin
      send_request(-16'sd50, 16'd30, 16'd0, 16'd0, 16'd100, 16'd0, m[1:0], 0);
      send_request(16'd250, -16'sd30, 16'd0, 16'd0, 16'd100, 16'd0, m[1:0], 0);
      send_request(16'd50, 16'd30, 16'd0, 16'd0, 16'd100, 16'd0, m[1:0], 0);
      send_request(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8001, 16'h7fff, m[1:0], 1);
    end

    // random part
    for (int i = 0; i < 1300; i++) begin
      sx = rand_coord(); sy = rand_coord();
      if ($urandom_range(0, 9) == 0) begin
        ex = sx; ey = sy;
      end else begin
        ex = rand_coord(); ey = rand_coord();
      end
      send_request(rand_coord(), rand_coord(), sx, sy, ex, ey, 2'($urandom),
                   i % 200 > 20);
    end
    start <= 1'b0;

    // drain
    wait_cnt = 0;
    while (pending_count != 0 && wait_cnt < 10 * LAT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LAT + 10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("PASS point_line_distance");
    else
      $display("FAIL point_line_distance");
    $finish;
  end
endmodule

`default_nettype wire
